FILE: src/kdc_pkg.sv
// Shared types, codes and the seven-segment table of the keyboard/display controller.
package kdc_pkg;

  // Bus access codes carried on command_i.
  typedef enum logic [1:0] {
    CMD_DATA_WR = 2'd0,
    CMD_CMD_WR  = 2'd1,
    CMD_DATA_RD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Command classes held in bits 7..5 of the command latch.
  typedef enum logic [2:0] {
    CLS_MODE        = 3'd0,
    CLS_CLOCK       = 3'd1,
    CLS_READ_SENSOR = 3'd2,
    CLS_READ_RAM    = 3'd3,
    CLS_WRITE_RAM   = 3'd4,
    CLS_INHIBIT     = 3'd5,
    CLS_CLEAR       = 3'd6,
    CLS_END_INT     = 3'd7
  } cls_e;

  localparam int unsigned RamDepth = 16;
  localparam int unsigned AddrW    = 4;

  localparam logic [7:0] ReadIdle   = 8'hff;
  localparam logic [7:0] ClearZero  = 8'h00;
  localparam logic [7:0] ClearSpace = 8'h20;
  localparam logic [7:0] ClearOnes  = 8'hff;

  // One result as it leaves the core.
  typedef struct packed {
    logic [7:0] read_data;
    logic       digit_valid;
    logic [3:0] digit_index;
    logic [6:0] segments_low;
    logic [6:0] segments_high;
  } result_t;

  // Seven-segment pattern of one nibble.
  function automatic logic [6:0] seg7(input logic [3:0] nib);
    logic [7:0] pat;
    case (nib)
      4'h0: pat = 8'h3f;
      4'h1: pat = 8'h06;
      4'h2: pat = 8'h5b;
      4'h3: pat = 8'h4f;
      4'h4: pat = 8'h66;
      4'h5: pat = 8'h6d;
      4'h6: pat = 8'h7c;
      4'h7: pat = 8'h07;
      4'h8: pat = 8'h7f;
      4'h9: pat = 8'h67;
      4'ha: pat = 8'h58;
      4'hb: pat = 8'h4c;
      4'hc: pat = 8'h62;
      4'hd: pat = 8'h69;
      4'he: pat = 8'h78;
      default: pat = 8'h00;
    endcase
    return pat[6:0];
  endfunction

endpackage

FILE: src/kdc_core.sv
// Command decode, controller state and display RAM of the keyboard/display controller.
module kdc_core import kdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [1:0] command_i,
  input  logic [7:0] data_i,
  input  logic [7:0] sensor_byte_i,
  output result_t    result_o
);

  logic [7:0]          latch_q, latch_d;
  logic [3:0]          inhibit_q, inhibit_d;
  logic [7:0]          clear_q, clear_d;
  logic [7:0]          fill_q, fill_d;
  logic [RamDepth-1:0] ram_valid_q;
  logic [7:0]          ram_q [RamDepth];

  logic [AddrW-1:0] addr;
  logic [7:0]       entry;
  logic [7:0]       wr_val;
  logic [7:0]       new_clear;
  logic             ram_we;
  logic             fill_en;
  logic [3:0]       nib_lo;
  logic [3:0]       nib_hi;
  cls_e             cls;
  cmd_e             cmd;

  assign cls  = cls_e'(latch_q[7:5]);
  assign cmd  = cmd_e'(command_i);
  assign addr = latch_q[AddrW-1:0];

  // An entry not written since the last fill reads as the fill value.
  assign entry = ram_valid_q[addr] ? ram_q[addr] : fill_q;

  // Merge the written byte under the nibble write-inhibit bits.
  assign wr_val = {inhibit_q[3] ? entry[7:4] : data_i[7:4],
                   inhibit_q[2] ? entry[3:0] : data_i[3:0]};

  // A blanked nibble shows the matching nibble of the clear value.
  assign nib_lo = inhibit_q[0] ? clear_q[3:0] : wr_val[3:0];
  assign nib_hi = inhibit_q[1] ? clear_q[7:4] : wr_val[7:4];

  assign new_clear = data_i[3] ? (data_i[2] ? ClearOnes : ClearSpace) : ClearZero;

  // Decode one request into the next state and its result.
  always_comb begin
    latch_d   = latch_q;
    inhibit_d = inhibit_q;
    clear_d   = clear_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    fill_en   = 1'b0;
    result_o  = '{read_data: ReadIdle, digit_valid: 1'b0, digit_index: '0,
                  segments_low: '0, segments_high: '0};
    unique case (cmd)
      CMD_DATA_WR: begin
        if (cls == CLS_WRITE_RAM) begin
          ram_we                 = 1'b1;
          result_o.digit_valid   = 1'b1;
          result_o.digit_index   = addr;
          result_o.segments_low  = seg7(nib_lo);
          result_o.segments_high = seg7(nib_hi);
          if (latch_q[4]) begin
            latch_d[3:0] = addr + 4'd1;
          end
        end
      end
      CMD_CMD_WR: begin
        latch_d = data_i;
        if (data_i[7:5] == CLS_INHIBIT) begin
          inhibit_d = data_i[3:0];
        end else if (data_i[7:5] == CLS_CLEAR) begin
          clear_d = new_clear;
          if (data_i[0] || data_i[4]) begin
            fill_en = 1'b1;
            fill_d  = new_clear;
          end
        end
      end
      CMD_DATA_RD: begin
        if (cls == CLS_READ_SENSOR) begin
          result_o.read_data = sensor_byte_i;
          if (latch_q[4]) begin
            latch_d[3:0] = {1'b0, latch_q[2:0]} + 4'd1;
          end
        end else if (cls == CLS_READ_RAM) begin
          result_o.read_data = entry;
          if (latch_q[4]) begin
            latch_d[3:0] = addr + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers and per-entry valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= '0;
      inhibit_q   <= '0;
      clear_q     <= '0;
      fill_q      <= '0;
      ram_valid_q <= '0;
    end else if (valid_i) begin
      latch_q   <= latch_d;
      inhibit_q <= inhibit_d;
      clear_q   <= clear_d;
      fill_q    <= fill_d;
      if (fill_en) begin
        ram_valid_q <= '0;
      end else if (ram_we) begin
        ram_valid_q[addr] <= 1'b1;
      end
    end
  end

  // Display RAM contents.
  always_ff @(posedge clk_i) begin
    if (valid_i && ram_we) begin
      ram_q[addr] <= wr_val;
    end
  end

  // A fill leaves every entry reading as the new clear value.
  a_fill_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && fill_en |=> ram_valid_q == '0 && fill_q == clear_q)
    else $error("fill did not reset the display RAM");

  // A RAM write always marks its entry as written.
  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ram_we |=> ram_valid_q[$past(addr)])
    else $error("written entry not marked valid");

  // Only a command write can change the clear value or the inhibit bits.
  a_clear_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_i && cmd == CMD_CMD_WR) |=> $stable(clear_q) && $stable(inhibit_q))
    else $error("clear value or inhibit bits changed without a command write");

endmodule

FILE: src/keyboard_display_controller.sv
// Top level of the keyboard/display controller: request register, core and result register.
//
// Each request (start_i while busy_o is low) is one processor bus access: a data write,
// a command write or a data read. busy_o is never raised, so a request may be issued in
// every cycle. The request is registered, decoded against the controller state in the
// following cycle, and its single result is captured in the result register and appears
// on the result ports for exactly one cycle with done_o high; results cannot be held off.
// Back-to-back requests see the state left by the one before. The display RAM reads as
// all zeros after reset and as the new clear value after a clear-with-fill command,
// without any sweep.
module keyboard_display_controller import kdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_i,
  input  logic [7:0] sensor_byte_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       digit_valid_o,
  output logic [3:0] digit_index_o,
  output logic [6:0] segments_low_o,
  output logic [6:0] segments_high_o
);

  logic       req_valid_q;
  logic [1:0] cmd_q;
  logic [7:0] data_q;
  logic [7:0] sensor_q;
  logic       done_q;
  result_t    res_d;
  result_t    res_q;

  assign busy_o = 1'b0;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q    <= command_i;
      data_q   <= data_i;
      sensor_q <= sensor_byte_i;
    end
  end

  kdc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (req_valid_q),
    .command_i     (cmd_q),
    .data_i        (data_q),
    .sensor_byte_i (sensor_q),
    .result_o      (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o          = done_q;
  assign read_data_o     = res_q.read_data;
  assign digit_valid_o   = res_q.digit_valid;
  assign digit_index_o   = res_q.digit_index;
  assign segments_low_o  = res_q.segments_low;
  assign segments_high_o = res_q.segments_high;

  // Every request yields a result through the request and result registers.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o)
    else $error("request produced no result");

  // A display write never returns read data.
  a_write_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && digit_valid_o |-> read_data_o == ReadIdle)
    else $error("display write returned read data");

  // Without a display write the digit fields are zero.
  a_digit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !digit_valid_o |-> digit_index_o == '0 && segments_low_o == '0
                                 && segments_high_o == '0)
    else $error("digit fields set without a display write");

endmodule

FILE: test/tb_keyboard_display_controller.sv
// Testbench for the keyboard/display controller: directed and random bus accesses, self-checked.
`timescale 1ns / 1ps

module tb_keyboard_display_controller;
  import kdc_pkg::*;

  localparam int unsigned DrainCycles = 4;
  localparam int unsigned DrainLimit  = 2000;

  // Seven-segment patterns, digits 0 through F.
  localparam logic [6:0] SegPattern [16] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7c, 7'h07,
    7'h7f, 7'h67, 7'h58, 7'h4c, 7'h62, 7'h69, 7'h78, 7'h00
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic [1:0] command_i = CMD_NONE;
  logic [7:0] data_i = 8'h00;
  logic [7:0] sensor_byte_i = 8'h00;
  logic       done_o;
  logic [7:0] read_data_o;
  logic       digit_valid_o;
  logic [3:0] digit_index_o;
  logic [6:0] segments_low_o;
  logic [6:0] segments_high_o;

  // Shadow copy of the controller state.
  logic [7:0] cmd_latch;
  logic [7:0] disp_ram [RamDepth];
  logic [3:0] inhibit_mask;
  logic [7:0] clear_byte;

  result_t    pending_results [$];
  int         mismatch_count;
  int         request_count;

  keyboard_display_controller u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .command_i,
    .data_i,
    .sensor_byte_i,
    .done_o,
    .read_data_o,
    .digit_valid_o,
    .digit_index_o,
    .segments_low_o,
    .segments_high_o
  );

  always #4 clk_i = ~clk_i;

  // Advance the address nibble of the latch when auto-increment is on.
  function automatic void step_address(logic [3:0] base);
    if (cmd_latch[4]) begin
      cmd_latch[3:0] = base + 4'd1;
    end
  endfunction

  // Work out the result of one bus access and update the shadow state.
  function automatic result_t predict_access(cmd_e cmd, logic [7:0] data, logic [7:0] sensor);
    result_t    res;
    cls_e       cls;
    logic [3:0] addr;
    logic [7:0] entry;
    logic [3:0] nib_lo;
    logic [3:0] nib_hi;
    res       = '0;
    res.read_data = ReadIdle;
    cls       = cls_e'(cmd_latch[7:5]);
    addr      = cmd_latch[3:0];
    case (cmd)
      CMD_DATA_WR: begin
        if (cls == CLS_WRITE_RAM) begin
          entry = disp_ram[addr];
          if (!inhibit_mask[2]) entry[3:0] = data[3:0];
          if (!inhibit_mask[3]) entry[7:4] = data[7:4];
          disp_ram[addr] = entry;
          nib_lo = inhibit_mask[0] ? clear_byte[3:0] : entry[3:0];
          nib_hi = inhibit_mask[1] ? clear_byte[7:4] : entry[7:4];
          res.digit_valid   = 1'b1;
          res.digit_index   = addr;
          res.segments_low  = SegPattern[nib_lo];
          res.segments_high = SegPattern[nib_hi];
          step_address(addr);
        end
      end
      CMD_CMD_WR: begin
        cmd_latch = data;
        if (cls_e'(data[7:5]) == CLS_INHIBIT) begin
          inhibit_mask = data[3:0];
        end else if (cls_e'(data[7:5]) == CLS_CLEAR) begin
          clear_byte = data[3] ? (data[2] ? ClearOnes : ClearSpace) : ClearZero;
          if (data[0] || data[4]) begin
            foreach (disp_ram[i]) disp_ram[i] = clear_byte;
          end
        end
      end
      CMD_DATA_RD: begin
        if (cls == CLS_READ_SENSOR) begin
          res.read_data = sensor;
          step_address({1'b0, cmd_latch[2:0]});
        end else if (cls == CLS_READ_RAM) begin
          res.read_data = disp_ram[addr];
          step_address(addr);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Issue one request and record its expected result once it is taken.
  task automatic send_access(cmd_e cmd, logic [7:0] data, logic [7:0] sensor);
    @(negedge clk_i);
    start_i       <= 1'b1;
    command_i     <= cmd;
    data_i        <= data;
    sensor_byte_i <= sensor;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(predict_access(cmd, data, sensor));
    request_count++;
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Randomly leave the bus idle after a request.
  task automatic pace(int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 4));
  endtask

  // Hold off requests until every expected result is back.
  task automatic wait_drain();
    int unsigned waited;
    waited = 0;
    idle_cycles(1);
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void note_mismatch(string what, result_t exp_res, result_t got_res);
    if (mismatch_count < 10) begin
      $display("MISMATCH %s: expected rd=%h dv=%b idx=%h lo=%h hi=%h, got rd=%h dv=%b idx=%h lo=%h hi=%h",
               what, exp_res.read_data, exp_res.digit_valid, exp_res.digit_index,
               exp_res.segments_low, exp_res.segments_high,
               got_res.read_data, got_res.digit_valid, got_res.digit_index,
               got_res.segments_low, got_res.segments_high);
    end
    mismatch_count++;
  endfunction

  // Compare each result strobe with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t got_res;
    result_t exp_res;
    if (rst_ni && done_o) begin
      got_res.read_data     = read_data_o;
      got_res.digit_valid   = digit_valid_o;
      got_res.digit_index   = digit_index_o;
      got_res.segments_low  = segments_low_o;
      got_res.segments_high = segments_high_o;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got_res);
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res.read_data !== exp_res.read_data ||
            got_res.digit_valid !== exp_res.digit_valid ||
            got_res.digit_index !== exp_res.digit_index ||
            got_res.segments_low !== exp_res.segments_low ||
            got_res.segments_high !== exp_res.segments_high) begin
          note_mismatch("result", exp_res, got_res);
        end
      end
    end
  end

  // RAM reads back zero after reset, with auto-increment.
  task automatic test_reset_contents();
    send_access(CMD_CMD_WR, {CLS_READ_RAM, 1'b1, 4'h0}, 8'h00);
    send_access(CMD_DATA_RD, 8'h00, 8'hff);
    send_access(CMD_DATA_RD, 8'hff, 8'h00);
  endtask

  // Sensor reads: the address restarts from bits 2..0 plus one.
  task automatic test_sensor_reads();
    send_access(CMD_CMD_WR, {CLS_READ_SENSOR, 1'b1, 4'hf}, 8'h00);
    send_access(CMD_DATA_RD, 8'h00, 8'h00);
    send_access(CMD_DATA_RD, 8'h00, 8'hff);
  endtask

  // Writes with wrap from the last entry, then read back.
  task automatic test_ram_writes();
    send_access(CMD_CMD_WR, {CLS_WRITE_RAM, 1'b1, 4'hf}, 8'h00);
    send_access(CMD_DATA_WR, 8'ha5, 8'h00);
    send_access(CMD_DATA_WR, 8'h5a, 8'h00);
    send_access(CMD_DATA_WR, 8'hff, 8'h00);
    send_access(CMD_CMD_WR, {CLS_READ_RAM, 1'b0, 4'hf}, 8'h00);
    send_access(CMD_DATA_RD, 8'h00, 8'h00);
  endtask

  // Write inhibit on each nibble and blanking of both nibbles.
  task automatic test_inhibit_blank();
    send_access(CMD_CMD_WR, {CLS_INHIBIT, 1'b0, 4'b0111}, 8'h00);
    send_access(CMD_CMD_WR, {CLS_WRITE_RAM, 1'b0, 4'h3}, 8'h00);
    send_access(CMD_DATA_WR, 8'hcd, 8'h00);
    send_access(CMD_CMD_WR, {CLS_INHIBIT, 1'b0, 4'b1000}, 8'h00);
    send_access(CMD_CMD_WR, {CLS_WRITE_RAM, 1'b1, 4'h3}, 8'h00);
    send_access(CMD_DATA_WR, 8'h9e, 8'h00);
  endtask

  // Clear values without fill, with fill by bit 0 and with fill by bit 4.
  task automatic test_clear_commands();
    send_access(CMD_CMD_WR, {CLS_CLEAR, 5'b01100}, 8'h00);
    send_access(CMD_CMD_WR, {CLS_CLEAR, 5'b01001}, 8'h00);
    send_access(CMD_CMD_WR, {CLS_CLEAR, 5'b11100}, 8'h00);
    send_access(CMD_CMD_WR, {CLS_INHIBIT, 1'b0, 4'b0011}, 8'h00);
    send_access(CMD_CMD_WR, {CLS_CLEAR, 5'b00101}, 8'h00);
  endtask

  // Accesses that only return the idle byte.
  task automatic test_ignored_accesses();
    send_access(CMD_DATA_WR, 8'h42, 8'h00);
    send_access(CMD_CMD_WR, {CLS_MODE, 5'h00}, 8'h00);
    send_access(CMD_DATA_RD, 8'h00, 8'h33);
    send_access(CMD_NONE, 8'hff, 8'hff);
    send_access(CMD_CMD_WR, {CLS_INHIBIT, 1'b0, 4'b0000}, 8'h00);
  endtask

  // Well-formed command/data bursts with random content, plus noise.
  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct);
    int unsigned target;
    int unsigned pick;
    int unsigned burst;
    logic [4:0]  clr_bits;
    target = request_count + n;
    while (request_count < target) begin
      pick  = $urandom_range(99);
      burst = $urandom_range(1, 20);
      if (pick < 30) begin
        send_access(CMD_CMD_WR, {CLS_WRITE_RAM, 5'($urandom)}, 8'($urandom));
        pace(idle_pct);
        repeat (burst) begin
          send_access(CMD_DATA_WR, 8'($urandom), 8'($urandom));
          pace(idle_pct);
        end
      end else if (pick < 45) begin
        send_access(CMD_CMD_WR, {CLS_READ_RAM, 5'($urandom)}, 8'($urandom));
        pace(idle_pct);
        repeat (burst) begin
          send_access(CMD_DATA_RD, 8'($urandom), 8'($urandom));
          pace(idle_pct);
        end
      end else if (pick < 55) begin
        send_access(CMD_CMD_WR, {CLS_READ_SENSOR, 5'($urandom)}, 8'($urandom));
        pace(idle_pct);
        repeat (burst) begin
          send_access(CMD_DATA_RD, 8'($urandom), 8'($urandom));
          pace(idle_pct);
        end
      end else if (pick < 65) begin
        send_access(CMD_CMD_WR, {CLS_INHIBIT, 5'($urandom)}, 8'($urandom));
        pace(idle_pct);
      end else if (pick < 70) begin
        // Keep fills rare so the RAM holds varied contents.
        clr_bits = 5'($urandom);
        if ($urandom_range(3) != 0) clr_bits = clr_bits & 5'b01110;
        send_access(CMD_CMD_WR, {CLS_CLEAR, clr_bits}, 8'($urandom));
        pace(idle_pct);
      end else begin
        send_access(cmd_e'($urandom_range(3)), 8'($urandom), 8'($urandom));
        pace(idle_pct);
      end
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    cmd_latch    = 8'h00;
    inhibit_mask = 4'h0;
    clear_byte   = ClearZero;
    foreach (disp_ram[i]) disp_ram[i] = 8'h00;
    mismatch_count = 0;
    request_count  = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_sensor_reads();
    test_ram_writes();
    test_inhibit_blank();
    test_clear_commands();
    test_ignored_accesses();

    test_random_traffic(500, 0);
    test_random_traffic(500, 46);
    wait_drain();
    test_random_traffic(500, 17);
    test_random_traffic(500, 46);

    wait_drain();
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
